[design/gaussian_noise_generator_defines.svh]
// Assertion macros for the Gaussian noise generator.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef GAUSSIAN_NOISE_GENERATOR_DEFINES_SVH
`define GAUSSIAN_NOISE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define GNG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gng assertion failed");
`define GNG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gng assertion failed");
`else
`define GNG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GNG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[design/gng_pkg.sv]
// Shared types, constants and helper functions for the Gaussian noise generator.
// No dependencies.
`default_nettype none
package gng_pkg;

    localparam int UNIFORM_BITS      = 53;
    localparam int APPROX_ITERATIONS = 32;
    localparam int ITER_W            = 6;
    localparam int SQRT_STEPS        = 32;
    localparam int UB_SHIFT          = 53 - UNIFORM_BITS;
    localparam int F_W               = 48;
    localparam int T_W               = 56;
    localparam int ACC_W             = 120;
    localparam int MUL_W             = 35;

    localparam logic [63:0]        GOLDEN_SEED   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0]        XS_MULT       = 64'h2545F4914F6CDD1D;
    localparam logic [63:0]        LN2_Q64       = 64'hB17217F7D1CF79AB;
    localparam logic [30:0]        HALF_PI_Q30   = 31'h6487ED51;
    localparam logic signed [33:0] CORDIC_GAIN   = 34'sh026DD3B6A;
    localparam logic [63:0]        REJECT_LIMIT  = 64'd9008;

    typedef struct packed {
        logic        cmd;
        logic [63:0] seed_value;
        logic [23:0] sigma;
    } gng_req_t;

    function automatic logic [63:0] xorshift64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x >> 12);
        b = a ^ (a << 25);
        return b ^ (b >> 27);
    endfunction

    function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
        logic [31:0] r;
        case (i)
            6'd0: r = 32'h3243F6A8;
            6'd1: r = 32'h1DAC6705;
            6'd2: r = 32'h0FADBAFC;
            6'd3: r = 32'h07F56EA6;
            6'd4: r = 32'h03FEAB76;
            6'd5: r = 32'h01FFD55B;
            6'd6: r = 32'h00FFFAAA;
            6'd7: r = 32'h007FFF55;
            6'd8: r = 32'h003FFFEA;
            6'd9: r = 32'h001FFFFD;
            default: begin
                if (i <= 6'd30) begin
                    r = 32'd1 << (6'd30 - i);
                end else begin
                    r = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [2*MUL_W-1:0] v);
        logic signed [31:0] r;
        if (v > 70'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -70'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/gng_mul.sv]
// Shared signed multiplier with registered product.
// Depends on gng_pkg for the operand width.
`default_nettype none
module gng_mul (
    input  logic                                aclk,
    input  logic signed [gng_pkg::MUL_W-1:0]    a,
    input  logic signed [gng_pkg::MUL_W-1:0]    b,
    output logic signed [2*gng_pkg::MUL_W-1:0]  p
);
    import gng_pkg::*;

    logic signed [2*MUL_W-1:0] p_reg;
    logic signed [2*MUL_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

[design/gng_core.sv]
// Sequencer and datapath: xorshift64*, log, square root, CORDIC and scaling,
// all sharing one multiplier. Depends on gng_pkg, gng_mul and the defines header.
`default_nettype none
`include "gaussian_noise_generator_defines.svh"
module gng_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  gng_pkg::gng_req_t req,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [31:0]       res_sample
);
    import gng_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_XS, S_UM0, S_UM1, S_UM2, S_UM3, S_NORM, S_LOG0, S_LOG, S_TCALC,
        S_H0, S_H1, S_H2, S_H3, S_H4, S_SQRT, S_TH0, S_TH1, S_CORD, S_MC, S_MS,
        S_ZS, S_SC0, S_SC1, S_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [63:0]              prng_reg, prng_next;
    logic                     cv_reg, cv_next;
    logic signed [31:0]       cache_reg, cache_next;
    logic [23:0]              sigma_reg, sigma_next;
    logic                     which_reg, which_next;
    logic [UNIFORM_BITS-1:0]  u1_reg, u1_next;
    logic [31:0]              ang_reg, ang_next;
    logic [63:0]              v_reg, v_next;
    logic [5:0]               nsh_reg, nsh_next;
    logic [ITER_W-1:0]        cnt_reg, cnt_next;
    logic [F_W-1:0]           f_reg, f_next;
    logic [T_W-1:0]           t_reg, t_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [63:0]              rem_reg, rem_next;
    logic [62:0]              res_reg, res_next;
    logic signed [33:0]       x_reg, x_next;
    logic signed [33:0]       y_reg, y_next;
    logic signed [32:0]       z_reg, z_next;
    logic signed [31:0]       zsc_reg, zsc_next;
    logic [31:0]              out_reg, out_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    logic [63:0]             lo64;
    logic [UNIFORM_BITS-1:0] u_val;
    logic [5:0]              amt;
    logic                    top_zero;
    logic [32:0]             sq;
    logic [31:0]             mnew;
    logic [62:0]             bitv;
    logic [63:0]             trial;
    logic [ACC_W-1:0]        accf;
    logic signed [33:0]      xs_sh, ys_sh;
    logic signed [32:0]      at_val;
    logic signed [33:0]      cos_v, sin_v;

    gng_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res_sample = out_reg;

    // quadrant rotation of the CORDIC result
    always_comb begin
        case (ang_reg[31:30])
            2'd0:    begin cos_v = x_reg;  sin_v = y_reg;  end
            2'd1:    begin cos_v = -y_reg; sin_v = x_reg;  end
            2'd2:    begin cos_v = -x_reg; sin_v = -y_reg; end
            default: begin cos_v = y_reg;  sin_v = -x_reg; end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        prng_next  = prng_reg;
        cv_next    = cv_reg;
        cache_next = cache_reg;
        sigma_next = sigma_reg;
        which_next = which_reg;
        u1_next    = u1_reg;
        ang_next   = ang_reg;
        v_next     = v_reg;
        nsh_next   = nsh_reg;
        cnt_next   = cnt_reg;
        f_next     = f_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zsc_next   = zsc_reg;
        out_next   = out_reg;
        mul_a      = '0;
        mul_b      = '0;

        lo64     = {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};
        u_val    = lo64[63:64-UNIFORM_BITS];
        amt      = 6'd32 >> cnt_reg[2:0];
        top_zero = ((v_reg >> (7'd64 - {1'b0, amt})) == 64'd0);
        sq       = mul_p[63:31];
        mnew     = sq[32] ? sq[32:1] : sq[31:0];
        bitv     = 63'd1 << (6'd62 - {cnt_reg[4:0], 1'b0});
        trial    = {1'b0, res_reg} + {1'b0, bitv};
        accf     = acc_reg + {mul_p[55:0], 64'd0};
        xs_sh    = x_reg >>> cnt_reg;
        ys_sh    = y_reg >>> cnt_reg;
        at_val   = {1'b0, atan_entry(cnt_reg)};

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    if (req.cmd) begin
                        prng_next = (req.seed_value == 64'd0) ? GOLDEN_SEED : req.seed_value;
                    end else begin
                        sigma_next = req.sigma;
                        if (cv_reg) begin
                            zsc_next   = cache_reg;
                            cv_next    = 1'b0;
                            state_next = S_SC0;
                        end else begin
                            which_next = 1'b0;
                            state_next = S_XS;
                        end
                    end
                end
            end
            S_XS: begin
                prng_next  = xorshift64(prng_reg);
                state_next = S_UM0;
            end
            // low 64 bits of state * multiplier from three partial products
            S_UM0: begin
                mul_a      = {3'b0, prng_reg[31:0]};
                mul_b      = {3'b0, XS_MULT[31:0]};
                state_next = S_UM1;
            end
            S_UM1: begin
                acc_next   = {56'd0, mul_p[63:0]};
                mul_a      = {3'b0, prng_reg[31:0]};
                mul_b      = {3'b0, XS_MULT[63:32]};
                state_next = S_UM2;
            end
            S_UM2: begin
                acc_next[63:32] = acc_reg[63:32] + mul_p[31:0];
                mul_a           = {3'b0, prng_reg[63:32]};
                mul_b           = {3'b0, XS_MULT[31:0]};
                state_next      = S_UM3;
            end
            S_UM3: begin
                if (!which_reg) begin
                    state_next = S_XS;
                    if ((64'(u_val) << UB_SHIFT) >= REJECT_LIMIT) begin
                        u1_next    = u_val;
                        which_next = 1'b1;
                    end
                end else begin
                    ang_next   = u_val[UNIFORM_BITS-1 -: 32];
                    v_next     = {u1_reg, {(64-UNIFORM_BITS){1'b0}}};
                    nsh_next   = '0;
                    cnt_next   = '0;
                    state_next = S_NORM;
                end
            end
            // leading-one search: shifts of 32, 16, 8, 4, 2, 1
            S_NORM: begin
                if (top_zero) begin
                    v_next   = v_reg << amt;
                    nsh_next = nsh_reg + amt;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd5) begin
                    state_next = S_LOG0;
                end
            end
            S_LOG0: begin
                mul_a      = {3'b0, v_reg[63:32]};
                mul_b      = {3'b0, v_reg[63:32]};
                f_next     = '0;
                cnt_next   = '0;
                state_next = S_LOG;
            end
            S_LOG: begin
                if (sq[32]) begin
                    f_next = f_reg | (F_W'(1) << (6'(F_W - 1) - cnt_reg));
                end
                mul_a    = {3'b0, mnew};
                mul_b    = {3'b0, mnew};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(APPROX_ITERATIONS - 1)) begin
                    state_next = S_TCALC;
                end
            end
            S_TCALC: begin
                t_next     = ((T_W'(nsh_reg) + T_W'(1)) << F_W) - T_W'(f_reg);
                state_next = S_H0;
            end
            // high half of t * ln2 from four partial products
            S_H0: begin
                mul_a      = {3'b0, t_reg[31:0]};
                mul_b      = {3'b0, LN2_Q64[31:0]};
                state_next = S_H1;
            end
            S_H1: begin
                acc_next   = {56'd0, mul_p[63:0]};
                mul_a      = {3'b0, t_reg[31:0]};
                mul_b      = {3'b0, LN2_Q64[63:32]};
                state_next = S_H2;
            end
            S_H2: begin
                acc_next   = acc_reg + {24'd0, mul_p[63:0], 32'd0};
                mul_a      = {11'b0, t_reg[T_W-1:32]};
                mul_b      = {3'b0, LN2_Q64[31:0]};
                state_next = S_H3;
            end
            S_H3: begin
                acc_next   = acc_reg + {24'd0, mul_p[63:0], 32'd0};
                mul_a      = {11'b0, t_reg[T_W-1:32]};
                mul_b      = {3'b0, LN2_Q64[63:32]};
                state_next = S_H4;
            end
            S_H4: begin
                rem_next   = {accf[118:64], 9'd0};
                res_next   = '0;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bitv;
                end else begin
                    res_next = res_reg >> 1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(SQRT_STEPS - 1)) begin
                    state_next = S_TH0;
                end
            end
            S_TH0: begin
                mul_a      = {5'b0, ang_reg[29:0]};
                mul_b      = {4'b0, HALF_PI_Q30};
                state_next = S_TH1;
            end
            S_TH1: begin
                z_next     = {2'b0, mul_p[60:30]};
                x_next     = CORDIC_GAIN;
                y_next     = '0;
                cnt_next   = '0;
                state_next = S_CORD;
            end
            S_CORD: begin
                if (z_reg >= 0) begin
                    x_next = x_reg - ys_sh;
                    y_next = y_reg + xs_sh;
                    z_next = z_reg - at_val;
                end else begin
                    x_next = x_reg + ys_sh;
                    y_next = y_reg - xs_sh;
                    z_next = z_reg + at_val;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(APPROX_ITERATIONS - 1)) begin
                    state_next = S_MC;
                end
            end
            S_MC: begin
                mul_a      = {3'b0, res_reg[31:0]};
                mul_b      = MUL_W'(cos_v);
                state_next = S_MS;
            end
            S_MS: begin
                zsc_next   = sat32(mul_p >>> 31);
                mul_a      = {3'b0, res_reg[31:0]};
                mul_b      = MUL_W'(sin_v);
                state_next = S_ZS;
            end
            S_ZS: begin
                cache_next = sat32(mul_p >>> 31);
                cv_next    = 1'b1;
                state_next = S_SC0;
            end
            S_SC0: begin
                mul_a      = MUL_W'(zsc_reg);
                mul_b      = {11'b0, sigma_reg};
                state_next = S_SC1;
            end
            S_SC1: begin
                // round half up, then back to Q15.16
                out_next   = sat32((mul_p + 70'sd67108864) >>> 27);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            prng_reg  <= GOLDEN_SEED;
            cv_reg    <= 1'b0;
            cache_reg <= '0;
        end else begin
            state_reg <= state_next;
            prng_reg  <= prng_next;
            cv_reg    <= cv_next;
            cache_reg <= cache_next;
        end
        sigma_reg <= sigma_next;
        which_reg <= which_next;
        u1_reg    <= u1_next;
        ang_reg   <= ang_next;
        v_reg     <= v_next;
        nsh_reg   <= nsh_next;
        cnt_reg   <= cnt_next;
        f_reg     <= f_next;
        t_reg     <= t_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        zsc_reg   <= zsc_next;
        out_reg   <= out_next;
    end

    `GNG_ASSERT_IMP(a_prng_nonzero, aclk, aresetn, 1'b1, prng_reg != 64'd0)
    `GNG_ASSERT_IMP(a_busy_while_result, aclk, aresetn, res_valid, !req_ready)
    `GNG_ASSERT_NXT(a_cache_hit_clears, aclk, aresetn, req_valid && req_ready && !req.cmd && cv_reg, !cv_reg && state_reg == S_SC0)
    `GNG_ASSERT_NXT(a_cache_filled, aclk, aresetn, state_reg == S_ZS, cv_reg)

endmodule
`default_nettype wire

[design/gaussian_noise_generator.sv]
// Gaussian noise generator: a draw with no cached sample takes u1 and u2 from
// xorshift64*, drawing again for every rejected u1, then runs the 32-step log,
// square root and CORDIC loops and scales the result; the second sample is cached.
// A draw served from the cached sample goes straight to scaling; a reseed only loads the seed.
// One request is processed at a time; a finished result waits in an output register.
// Reset (aresetn low, synchronous) loads the golden seed and empties the cache.
`default_nettype none
module gaussian_noise_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // seed_value[63:0], sigma[87:64]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sample[31:0]
);
    import gng_pkg::*;

    gng_req_t    req;
    logic        res_valid;
    logic        res_ready;
    logic [31:0] res_sample;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    assign req.cmd        = s_tuser[0];
    assign req.seed_value = s_tdata[63:0];
    assign req.sigma      = s_tdata[87:64];

    gng_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_sample (res_sample)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
